// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the floppy write encoder.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, off while reset is asserted
`define FME_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fme assertion failed");

// Consequent checked in the cycle after the antecedent
`define FME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fme assertion failed");

`endif

// ----- rtl/fme_pkg.sv -----
// Shared types, constants and encode/CRC functions of the floppy write encoder.
// Used by every module of the block; depends on nothing.
package fme_pkg;

  // Command codes
  typedef enum logic [2:0] {
    OP_DATA         = 3'd0,
    OP_INDEX_MARK   = 3'd1,
    OP_ID_MARK      = 3'd2,
    OP_DATA_MARK    = 3'd3,
    OP_DELETED_MARK = 3'd4,
    OP_CRC          = 3'd5
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MFM_MODE      = 3'd0,
    CFG_MFM_SYNC      = 3'd1,
    CFG_MFM_IDX_SYNC  = 3'd2,
    CFG_CRC_AFTER_SYN = 3'd3,
    CFG_INDEX_MARK    = 3'd4,
    CFG_ID_MARK       = 3'd5,
    CFG_DATA_MARK     = 3'd6,
    CFG_DELETED_MARK  = 3'd7
  } cfg_idx_e;

  localparam logic [15:0] CLOCK_BITS = 16'haaaa;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_PRESET = 16'hffff;
  localparam logic [1:0]  SYNC_WORDS = 2'd3;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic        mfm_mode;
    logic [15:0] mfm_sync_word;
    logic [15:0] mfm_index_sync_word;
    logic [15:0] crc_after_sync;
    logic [15:0] index_mark_word;
    logic [15:0] id_mark_word;
    logic [15:0] data_mark_word;
    logic [15:0] deleted_mark_word;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [15:0] cell_word;
    logic        last_word;
  } word_t;

  // Place byte bits on the even cell positions
  function automatic logic [15:0] spread_bits(input logic [7:0] b);
    logic [15:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s[2*i] = b[i];
    end
    return s;
  endfunction

  // Pick the data bits out of a cell word
  function automatic logic [7:0] gather_bits(input logic [15:0] w);
    logic [7:0] b;
    b = '0;
    for (int i = 0; i < 8; i++) begin
      b[i] = w[2*i];
    end
    return b;
  endfunction

  // CRC-16-CCITT, one byte, MSB first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // FM: clock in every odd cell; MFM: clock only between two zero data bits
  function automatic logic [15:0] encode_byte(input logic [7:0] b, input logic mfm,
                                              input logic prev);
    logic [15:0] s;
    logic [15:0] ors;
    s   = spread_bits(b);
    ors = {s[14:0], 1'b0} | {1'b0, s[15:1]} | {prev, 15'b0};
    return mfm ? (s | (~ors & CLOCK_BITS)) : (s | CLOCK_BITS);
  endfunction

endpackage

// ----- rtl/fme_cfg.sv -----
// Configuration register file of the floppy write encoder.
// Depends on fme_pkg.
module fme_cfg import fme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        cfg_ready_o,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mfm_mode            <= 1'b1;
      cfg_q.mfm_sync_word       <= 16'h4489;
      cfg_q.mfm_index_sync_word <= 16'h5224;
      cfg_q.crc_after_sync      <= 16'hcdb4;
      cfg_q.index_mark_word     <= 16'hf77a;
      cfg_q.id_mark_word        <= 16'hf57e;
      cfg_q.data_mark_word      <= 16'hf56f;
      cfg_q.deleted_mark_word   <= 16'hf56a;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MFM_MODE:      cfg_q.mfm_mode            <= cfg_data_i[0];
        CFG_MFM_SYNC:      cfg_q.mfm_sync_word       <= cfg_data_i;
        CFG_MFM_IDX_SYNC:  cfg_q.mfm_index_sync_word <= cfg_data_i;
        CFG_CRC_AFTER_SYN: cfg_q.crc_after_sync      <= cfg_data_i;
        CFG_INDEX_MARK:    cfg_q.index_mark_word     <= cfg_data_i;
        CFG_ID_MARK:       cfg_q.id_mark_word        <= cfg_data_i;
        CFG_DATA_MARK:     cfg_q.data_mark_word      <= cfg_data_i;
        CFG_DELETED_MARK:  cfg_q.deleted_mark_word   <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/fme_core.sv -----
// Command register, word sequencer, CRC and previous-bit state.
// Depends on fme_pkg; feeds fme_out.
module fme_core import fme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        bad_crc_i,
  input  logic        can_push_i,
  output logic        push_o,
  output word_t       word_o
);

  logic        cmd_valid_q;
  logic [2:0]  op_q;
  logic [7:0]  byte_q;
  logic        bad_q;
  logic [1:0]  cnt_q;
  logic [15:0] crc_q, crc_d;
  logic        prev_q;
  logic [7:0]  crc_lo_q;

  logic        emit, last, use_enc, crc_touch, done, accept;
  logic [7:0]  enc_in;
  logic [15:0] crc_base, raw_word, mark_w, sync_w, cell_w;

  // Mark and sync word for the current command
  always_comb begin
    case (op_q)
      OP_INDEX_MARK:   mark_w = cfg_i.index_mark_word;
      OP_ID_MARK:      mark_w = cfg_i.id_mark_word;
      OP_DATA_MARK:    mark_w = cfg_i.data_mark_word;
      default:         mark_w = cfg_i.deleted_mark_word;
    endcase
    sync_w = (op_q == OP_INDEX_MARK) ? cfg_i.mfm_index_sync_word : cfg_i.mfm_sync_word;
  end

  // Word selection for the current beat
  always_comb begin
    emit      = 1'b1;
    last      = 1'b1;
    use_enc   = 1'b1;
    crc_touch = 1'b1;
    enc_in    = byte_q;
    crc_base  = crc_q;
    raw_word  = mark_w;
    case (op_q)
      OP_DATA: ;
      OP_INDEX_MARK, OP_ID_MARK, OP_DATA_MARK, OP_DELETED_MARK: begin
        enc_in = gather_bits(mark_w);
        if (cfg_i.mfm_mode) begin
          if (cnt_q != SYNC_WORDS) begin
            // sync words: no CRC change
            use_enc   = 1'b0;
            crc_touch = 1'b0;
            raw_word  = sync_w;
            last      = 1'b0;
          end else if (op_q != OP_INDEX_MARK) begin
            crc_base = cfg_i.crc_after_sync;
          end
        end else begin
          // FM mark: preset CRC, add mark byte, send mark word
          use_enc  = 1'b0;
          crc_base = CRC_PRESET;
        end
      end
      OP_CRC: begin
        if (cnt_q == 2'd0) begin
          enc_in = crc_q[15:8];
          last   = 1'b0;
        end else begin
          enc_in = crc_lo_q ^ {7'b0, bad_q};
        end
      end
      default: begin
        emit      = 1'b0;
        crc_touch = 1'b0;
      end
    endcase
    cell_w = use_enc ? encode_byte(enc_in, cfg_i.mfm_mode, prev_q) : raw_word;
    crc_d  = crc_touch ? crc_add(crc_base, enc_in) : crc_q;
  end

  // Handshake
  assign push_o     = cmd_valid_q && emit && can_push_i;
  assign done       = cmd_valid_q && last && (can_push_i || !emit);
  assign in_stall_o = cmd_valid_q && !done;
  assign accept     = in_valid_i && !in_stall_o;
  assign word_o     = '{cell_word: cell_w, last_word: last};

  // Command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
    end else if (accept) begin
      cmd_valid_q <= 1'b1;
      cnt_q       <= 2'd0;
    end else if (done) begin
      cmd_valid_q <= 1'b0;
    end else if (push_o) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
      bad_q  <= bad_crc_i;
    end
  end

  // Running CRC and last data bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_PRESET;
      prev_q <= 1'b0;
    end else if (push_o) begin
      crc_q  <= crc_d;
      prev_q <= cell_w[0];
    end
  end

  // Low CRC byte held for the second beat of a CRC command
  always_ff @(posedge clk_i) begin
    if (push_o && op_q == OP_CRC && cnt_q == 2'd0) begin
      crc_lo_q <= crc_q[7:0];
    end
  end

endmodule

// ----- rtl/fme_out.sv -----
// Output register of the floppy write encoder.
// Depends on fme_pkg; driven by fme_core.
module fme_out import fme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  word_t       word_i,
  output logic        can_push_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cell_word_o,
  output logic        last_word_o
);

  logic  valid_q;
  word_t word_q;

  // Register is free when empty or being taken this cycle
  assign can_push_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign cell_word_o = word_q.cell_word;
  assign last_word_o = word_q.last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_push_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_push_o && push_i) begin
      word_q <= word_i;
    end
  end

endmodule

// ----- rtl/fm_mfm_floppy_encoder.sv -----
// A command's first word passes the command register, then the output register.
// Throughput: one data-byte command per cycle unless the output stalls; a command holds
// the command register until its words go out (MFM mark 4, FM mark 1, CRC 2, unused 0).
// Reset: CRC preset to ffff, previous data bit cleared, registers to defaults, no beats.
// Top level of the floppy write encoder; depends on fme_pkg, fme_cfg, fme_core, fme_out.
module fm_mfm_floppy_encoder import fme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        bad_crc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cell_word_o,
  output logic        last_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t  cfg;
  logic  can_push;
  logic  push;
  word_t word;

  fme_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .cfg_ready_o,
    .cfg_o(cfg)
  );

  fme_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i, .in_stall_o, .op_i, .data_byte_i,
    .bad_crc_i, .can_push_i(can_push), .push_o(push), .word_o(word)
  );

  fme_out u_out (
    .clk_i, .rst_ni, .push_i(push), .word_i(word), .can_push_o(can_push),
    .out_valid_o, .out_stall_i, .cell_word_o, .last_word_o
  );

endmodule

// ----- rtl/fme_checker.sv -----
// Port-level checker for the floppy write encoder, bound to the top level.
// Depends on assert_macros.svh and fme_pkg.
`include "assert_macros.svh"

module fme_checker import fme_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  op_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] cell_word_o,
  input logic        last_word_o
);

  logic in_take, out_take, out_wait;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;
  assign out_wait = out_valid_o && out_stall_i;

  // Stalled result beat holds
  `FME_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable({cell_word_o, last_word_o}))

  // Words of one command follow back to back once the output moves
  `FME_ASSERT_NEXT(a_cmd_stream, out_take && !last_word_o, out_valid_o)

  // A data byte with a free output path shows up as a single closing word
  `FME_ASSERT(a_data_latency, (in_take && op_i == OP_DATA) ##1 !out_wait |=> (out_valid_o && last_word_o))

endmodule

bind fm_mfm_floppy_encoder fme_checker u_fme_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking bench for fm_mfm_floppy_encoder: a directed command table, then random
// command traffic under several register settings, each beat checked against a predictor.
// Depends on fme_pkg and the encoder RTL.
module testbench;
  import fme_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 24;
  localparam int PHASES        = 5;
  localparam int DIRECTED_ROWS = 25;
  localparam int FM_ROW        = 17;
  localparam int MAX_REPORTS   = 10;

  // Codes outside op_e: the block accepts and drops them
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam cfg_t RESET_CFG = '{1'b1, 16'h4489, 16'h5224, 16'hcdb4,
                                 16'hf77a, 16'hf57e, 16'hf56f, 16'hf56a};

  // Directed row; word is the first cell word when known is set
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data;
    logic        bad;
    logic        known;
    logic [15:0] word;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [7:0]  data_byte_i;
  logic        bad_crc_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] cell_word_o;
  logic        last_word_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Predictor state
  cfg_t        cfg_q;
  logic [15:0] crc_q;
  logic        prev_cell;
  logic [15:0] burst[$];
  word_t       expected_words[$];

  logic idling = 1'b1;
  int   mismatches = 0;
  int   cycle_count = 0;

  fm_mfm_floppy_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .bad_crc_i   (bad_crc_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_word_o (cell_word_o),
    .last_word_o (last_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Output backpressure
  always @(posedge clk_i) begin
    out_stall_i <= idling && ($urandom_range(99) < 10);
  end

  // Compare each output beat with the oldest expected word
  always @(posedge clk_i) begin : check_words
    word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word %h last %b", cell_word_o, last_word_o);
      end else begin
        want = expected_words.pop_front();
        if (cell_word_o !== want.cell_word || last_word_o !== want.last_word) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("word mismatch: expected %h last %b, got %h last %b",
                     want.cell_word, want.last_word, cell_word_o, last_word_o);
        end
      end
    end
  end

  // CRC-16-CCITT, fed one bit at a time, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Cells for one byte in the current mode; the byte also goes into the CRC
  function automatic logic [15:0] cells_of(input logic [7:0] b);
    logic [15:0] w;
    logic        left;
    crc_q = crc_step(crc_q, b);
    left  = prev_cell;
    w     = '0;
    for (int i = 7; i >= 0; i--) begin
      w[2*i]   = b[i];
      w[2*i+1] = cfg_q.mfm_mode ? ~(left | b[i]) : 1'b1;
      left     = b[i];
    end
    return w;
  endfunction

  function automatic void emit(input logic [15:0] w);
    burst.insert(burst.size(), w);
    prev_cell = w[0];
  endfunction

  // Expected words of one accepted command; a typed word replaces the first one
  task automatic predict_cmd(input logic [2:0] op, input logic [7:0] b, input logic bad,
                             input logic known, input logic [15:0] word);
    logic [15:0] mark;
    logic [15:0] c;
    logic [7:0]  mark_byte;
    burst.delete();
    case (op)
      OP_DATA: emit(cells_of(b));
      OP_INDEX_MARK, OP_ID_MARK, OP_DATA_MARK, OP_DELETED_MARK: begin
        case (op)
          OP_INDEX_MARK: mark = cfg_q.index_mark_word;
          OP_ID_MARK:    mark = cfg_q.id_mark_word;
          OP_DATA_MARK:  mark = cfg_q.data_mark_word;
          default:       mark = cfg_q.deleted_mark_word;
        endcase
        for (int i = 0; i < 8; i++) mark_byte[i] = mark[2*i];
        if (cfg_q.mfm_mode) begin
          repeat (SYNC_WORDS)
            emit(op == OP_INDEX_MARK ? cfg_q.mfm_index_sync_word : cfg_q.mfm_sync_word);
          if (op != OP_INDEX_MARK) crc_q = cfg_q.crc_after_sync;
          emit(cells_of(mark_byte));
        end else begin
          crc_q = crc_step(CRC_PRESET, mark_byte);
          emit(mark);
        end
      end
      OP_CRC: begin
        c = crc_q;
        emit(cells_of(c[15:8]));
        emit(cells_of(c[7:0] ^ {7'd0, bad}));
      end
      default: ;
    endcase
    if (known && burst.size() > 0) burst[0] = word;
    foreach (burst[i])
      expected_words.insert(expected_words.size(),
                            '{cell_word: burst[i], last_word: i == burst.size() - 1});
  endtask

  // One command beat, after a random gap; valid stays high on return
  task automatic send_cmd(input logic [2:0] op, input logic [7:0] b, input logic bad,
                          input logic known = 1'b0, input logic [15:0] word = 16'h0000);
    int gap;
    gap = 0;
    while (idling && $urandom_range(99) < 10) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    bad_crc_i   <= bad;
    do @(posedge clk_i); while (in_stall_o);
    predict_cmd(op, b, bad, known, word);
  endtask

  // Wait until every expected word is out and a dropped code has cleared
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers back to back
  task automatic load_setting(input cfg_t s);
    cfg_idx_e    idx;
    logic [15:0] v;
    idx = idx.first();
    do begin
      case (idx)
        CFG_MFM_MODE:      v = {15'd0, s.mfm_mode};
        CFG_MFM_SYNC:      v = s.mfm_sync_word;
        CFG_MFM_IDX_SYNC:  v = s.mfm_index_sync_word;
        CFG_CRC_AFTER_SYN: v = s.crc_after_sync;
        CFG_INDEX_MARK:    v = s.index_mark_word;
        CFG_ID_MARK:       v = s.id_mark_word;
        CFG_DATA_MARK:     v = s.data_mark_word;
        CFG_DELETED_MARK:  v = s.deleted_mark_word;
        default:           v = 16'h0000;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= v;
      do @(posedge clk_i); while (!cfg_ready_o);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid_i <= 1'b0;
    cfg_q = s;
  endtask

  // Mostly mark / data / CRC records with random content, some raw noise
  task automatic run_traffic(input int count);
    int         sent;
    int         len;
    logic [2:0] op_any;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(3) != 0) begin
          send_cmd(3'($urandom_range(OP_DELETED_MARK, OP_INDEX_MARK)),
                   8'($urandom), 1'($urandom));
          sent++;
        end
        len = $urandom_range(8, 1);
        repeat (len) send_cmd(OP_DATA, 8'($urandom), 1'($urandom));
        send_cmd(OP_CRC, 8'($urandom), $urandom_range(3) == 0);
        sent += len + 1;
      end else begin
        op_any = 3'($urandom_range(OP_UNUSED_HI));
        send_cmd(op_any, 8'($urandom), 1'($urandom));
        if (op_any <= OP_CRC) sent++;
      end
    end
  endtask

  initial begin
    dir_row_t rows [DIRECTED_ROWS];
    cfg_t     s;

    rows = '{
      // MFM after reset: clock bits follow the data and the previous word
      '{OP_DATA,         8'h00, 1'b0, 1'b1, 16'haaaa},
      '{OP_DATA,         8'hff, 1'b0, 1'b1, 16'h5555},
      '{OP_DATA,         8'h00, 1'b1, 1'b1, 16'h2aaa},
      '{OP_DATA,         8'h80, 1'b0, 1'b0, 16'h0000},
      '{OP_DATA,         8'h01, 1'b1, 1'b0, 16'h0000},
      '{OP_INDEX_MARK,   8'hff, 1'b1, 1'b1, 16'h5224},
      '{OP_DATA,         8'ha5, 1'b0, 1'b0, 16'h0000},
      '{OP_ID_MARK,      8'h00, 1'b0, 1'b1, 16'h4489},
      '{OP_DATA,         8'hfe, 1'b0, 1'b0, 16'h0000},
      '{OP_CRC,          8'h00, 1'b0, 1'b0, 16'h0000},
      '{OP_DATA_MARK,    8'h00, 1'b0, 1'b1, 16'h4489},
      '{OP_DATA,         8'h5a, 1'b0, 1'b0, 16'h0000},
      '{OP_CRC,          8'h00, 1'b1, 1'b0, 16'h0000},
      '{OP_DELETED_MARK, 8'h00, 1'b0, 1'b1, 16'h4489},
      '{OP_UNUSED_LO,    8'hff, 1'b1, 1'b0, 16'h0000},
      '{OP_CRC,          8'hff, 1'b0, 1'b0, 16'h0000},
      '{OP_UNUSED_HI,    8'h00, 1'b0, 1'b0, 16'h0000},
      // FM with default mark words
      '{OP_DATA,         8'h00, 1'b0, 1'b1, 16'haaaa},
      '{OP_DATA,         8'hff, 1'b0, 1'b1, 16'hffff},
      '{OP_INDEX_MARK,   8'h00, 1'b0, 1'b1, 16'hf77a},
      '{OP_ID_MARK,      8'h00, 1'b0, 1'b1, 16'hf57e},
      '{OP_DATA,         8'hff, 1'b0, 1'b0, 16'h0000},
      '{OP_CRC,          8'h00, 1'b1, 1'b0, 16'h0000},
      '{OP_DATA_MARK,    8'h00, 1'b0, 1'b1, 16'hf56f},
      '{OP_DELETED_MARK, 8'h00, 1'b0, 1'b1, 16'hf56a}
    };

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    op_i        <= OP_DATA;
    data_byte_i <= 8'h00;
    bad_crc_i   <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_MFM_MODE;
    cfg_data_i  <= 16'h0000;
    cfg_q     = RESET_CFG;
    crc_q     = CRC_PRESET;
    prev_cell = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, switching to FM partway through
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (r == FM_ROW) begin
        settle();
        s = RESET_CFG;
        s.mfm_mode = 1'b0;
        load_setting(s);
      end
      send_cmd(rows[r].op, rows[r].data, rows[r].bad, rows[r].known, rows[r].word);
    end

    // Random traffic: all-zero FM, all-ones MFM, defaults without idling, then random
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: s = '0;
        1: s = '1;
        2: s = RESET_CFG;
        default: begin
          s.mfm_mode            = (p == 3);
          s.mfm_sync_word       = 16'($urandom);
          s.mfm_index_sync_word = 16'($urandom);
          s.crc_after_sync      = 16'($urandom);
          s.index_mark_word     = 16'($urandom);
          s.id_mark_word        = 16'($urandom);
          s.data_mark_word      = 16'($urandom);
          s.deleted_mark_word   = 16'($urandom);
        end
      endcase
      idling = (p != 2);
      load_setting(s);
      run_traffic(PHASE_ITEMS);
    end

    settle();
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fme_pkg.sv
rtl/fme_cfg.sv
rtl/fme_core.sv
rtl/fme_out.sv
rtl/fm_mfm_floppy_encoder.sv
rtl/fme_checker.sv
sim/testbench.sv
